FILE: rtl/core/draw_bin_hash_table_defines.svh
// ----------------------------------------------------------------------------
// draw bin hash table assertion macros
// shared concurrent assertion forms for the bin table rtl
// ----------------------------------------------------------------------------
`ifndef DRAW_BIN_HASH_TABLE_DEFINES_SVH
`define DRAW_BIN_HASH_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DBH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("draw bin hash table: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define DBH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("draw bin hash table: next-cycle check failed");

`endif

FILE: rtl/core/dbh_pkg.sv
// ----------------------------------------------------------------------------
// dbh_pkg
// shared types, codes and constants of the draw bin hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dbh_pkg;

  localparam int unsigned DEF_TABLE_DEPTH  = 1024;
  localparam int unsigned DEF_COMMAND_BITS = 20;

  localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME  = 32'd16777619;
  localparam int unsigned FOLD_SHIFT = 16;

  localparam int unsigned LG_W     = 4;
  localparam int unsigned BIN_W    = 9;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned FIELD_CW = 20;
  localparam int unsigned PA_W     = 7;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STEP_W   = 3;

  localparam logic [LG_W-1:0]   SIZE_LG_RESET = 4'd10;
  localparam logic [STEP_W-1:0] LAST_STEP     = 3'd4;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_FIND   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_INS  = 2'd1,
    RES_HIT  = 2'd2
  } res_sel_t;

  // controller to datapath
  typedef struct packed {
    logic              idle;
    logic              clear_counts;
    logic              sweep_start;
    logic              sweep_step;
    logic              hash_step;
    logic [STEP_W-1:0] word_sel;
    logic              seed;
    logic              read_en;
    logic              advance;
    logic              ins_write;
    logic              out_load;
    status_t           out_status;
    res_sel_t          res_sel;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic  in_valid;
    func_t func_in;
    func_t func_q;
    logic  sweep_last;
    logic  precheck_full;
    logic  precheck_ovf;
    logic  slot_valid;
    logic  slot_match;
    logic  probe_last;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/dbh_datapath.sv
// ----------------------------------------------------------------------------
// dbh_datapath
// key registers, fnv hash unit, slot memory, counters and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module dbh_datapath
  import dbh_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int unsigned COMMAND_BITS = DEF_COMMAND_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output sts_t                     sts,
  input  wire logic                cfg_wr_en,
  input  wire logic [LG_W-1:0]     cfg_wr_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_func,
  input  wire logic [3:0]          in_phase,
  input  wire logic [2:0]          in_alpha,
  input  wire logic [WORD_W-1:0]   in_pipeline,
  input  wire logic [WORD_W-1:0]   in_geometry_heap,
  input  wire logic [WORD_W-1:0]   in_material_template,
  input  wire logic [FIELD_CW-1:0] in_demand,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic [BIN_W-1:0]         out_bin_index,
  output logic [FIELD_CW-1:0]      out_first_command,
  output logic [FIELD_CW-1:0]      out_bin_capacity,
  output logic [CNT_W-1:0]         out_active_bins,
  output logic [FIELD_CW-1:0]      out_total_commands
);

  localparam int unsigned ADDR_W    = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;
  localparam int unsigned CB        = COMMAND_BITS;
  localparam int unsigned SW        = ((CB > FIELD_CW) ? CB : FIELD_CW) + 1;
  localparam logic [4:0]  ADDR_W_L  = 5'(ADDR_W);
  localparam logic [SW-1:0] CMD_MAX = {{(SW-CB){1'b0}}, {CB{1'b1}}};
  localparam logic [ADDR_W-1:0] SWEEP_END = ADDR_W'(MEM_DEPTH - 1);

  logic [LG_W-1:0]     size_lg_r;
  logic [1:0]          func_r;
  logic [PA_W-1:0]     pa_r;
  logic [WORD_W-1:0]   pipe_r, heap_r, mat_r, h_r;
  logic [FIELD_CW-1:0] demand_r;
  logic [ADDR_W-1:0]   idx_r, probe_r, mask_r, sweep_r;
  logic [ADDR_W:0]     bin_cnt_r;
  logic [CB-1:0]       cmd_tot_r;
  logic [BIN_W-1:0]    hold_bin_r;
  logic [CB-1:0]       hold_first_r;
  logic [FIELD_CW-1:0] hold_cap_r;
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [BIN_W-1:0]    out_bin_r;
  logic [FIELD_CW-1:0] out_first_r, out_cap_r, out_total_r;
  logic [CNT_W-1:0]    out_active_r;

  // slot memory, one address for all fields
  logic                mem_valid [MEM_DEPTH];
  logic [PA_W-1:0]     mem_pa    [MEM_DEPTH];
  logic [WORD_W-1:0]   mem_pipe  [MEM_DEPTH];
  logic [WORD_W-1:0]   mem_heap  [MEM_DEPTH];
  logic [WORD_W-1:0]   mem_mat   [MEM_DEPTH];
  logic [BIN_W-1:0]    mem_bin   [MEM_DEPTH];
  logic [CB-1:0]       mem_off   [MEM_DEPTH];
  logic [FIELD_CW-1:0] mem_cap   [MEM_DEPTH];

  logic                rd_valid_r;
  logic [PA_W-1:0]     rd_pa_r;
  logic [WORD_W-1:0]   rd_pipe_r, rd_heap_r, rd_mat_r;
  logic [BIN_W-1:0]    rd_bin_r;
  logic [CB-1:0]       rd_off_r;
  logic [FIELD_CW-1:0] rd_cap_r;

  logic                accept;
  logic [4:0]          lg_ext, lg_eff;
  logic [ADDR_W:0]     slots, slots_m1;
  logic [WORD_W-1:0]   word, h_nxt, fold;
  logic [SW-1:0]       sum, first_ext, total_ext;
  logic [ADDR_W+1:0]   bin_dbl;

  assign accept   = cmd.idle && in_valid;
  assign in_stall = !cmd.idle;

  assign lg_ext   = {1'b0, size_lg_r};
  assign lg_eff   = (lg_ext > ADDR_W_L) ? ADDR_W_L : lg_ext;
  assign slots    = {{ADDR_W{1'b0}}, 1'b1} << lg_eff;
  assign slots_m1 = slots - 1'b1;

  always_comb begin
    case (cmd.word_sel)
      3'd0:    word = {28'd0, pa_r[6:3]};
      3'd1:    word = {29'd0, pa_r[2:0]};
      3'd2:    word = pipe_r;
      3'd3:    word = heap_r;
      default: word = mat_r;
    endcase
  end

  assign h_nxt = (h_r ^ word) * FNV_PRIME;
  assign fold  = h_r ^ (h_r >> FOLD_SHIFT);

  assign sum       = SW'(cmd_tot_r) + SW'(demand_r);
  assign bin_dbl   = {bin_cnt_r, 1'b0};
  assign first_ext = SW'(hold_first_r);
  assign total_ext = SW'(cmd_tot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_lg_r <= SIZE_LG_RESET;
    end else if (cfg_wr_en) begin
      size_lg_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      pa_r     <= {in_phase, in_alpha};
      pipe_r   <= in_pipeline;
      heap_r   <= in_geometry_heap;
      mat_r    <= in_material_template;
      demand_r <= in_demand;
      h_r      <= FNV_BASIS;
    end else if (cmd.hash_step) begin
      h_r <= h_nxt;
    end
    if (cmd.seed) begin
      idx_r   <= fold[ADDR_W-1:0] & slots_m1[ADDR_W-1:0];
      mask_r  <= slots_m1[ADDR_W-1:0];
      probe_r <= '0;
    end else if (cmd.advance) begin
      idx_r   <= (idx_r + 1'b1) & mask_r;
      probe_r <= probe_r + 1'b1;
    end
    if (cmd.ins_write) begin
      hold_bin_r   <= BIN_W'(bin_cnt_r);
      hold_first_r <= cmd_tot_r;
      hold_cap_r   <= demand_r;
    end else if (cmd.res_sel == RES_HIT && cmd.out_load) begin
      hold_bin_r   <= rd_bin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r   <= '0;
      bin_cnt_r <= '0;
      cmd_tot_r <= '0;
    end else begin
      if (cmd.sweep_start) begin
        sweep_r <= '0;
      end else if (cmd.sweep_step) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.clear_counts) begin
        bin_cnt_r <= '0;
        cmd_tot_r <= '0;
      end else if (cmd.ins_write) begin
        bin_cnt_r <= bin_cnt_r + 1'b1;
        cmd_tot_r <= sum[CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep_step) begin
      mem_valid[sweep_r] <= 1'b0;
    end else if (cmd.ins_write) begin
      mem_valid[idx_r] <= 1'b1;
      mem_pa[idx_r]    <= pa_r;
      mem_pipe[idx_r]  <= pipe_r;
      mem_heap[idx_r]  <= heap_r;
      mem_mat[idx_r]   <= mat_r;
      mem_bin[idx_r]   <= BIN_W'(bin_cnt_r);
      mem_off[idx_r]   <= cmd_tot_r;
      mem_cap[idx_r]   <= demand_r;
    end
    if (cmd.read_en) begin
      rd_valid_r <= mem_valid[idx_r];
      rd_pa_r    <= mem_pa[idx_r];
      rd_pipe_r  <= mem_pipe[idx_r];
      rd_heap_r  <= mem_heap[idx_r];
      rd_mat_r   <= mem_mat[idx_r];
      rd_bin_r   <= mem_bin[idx_r];
      rd_off_r   <= mem_off[idx_r];
      rd_cap_r   <= mem_cap[idx_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  logic [SW-1:0] rd_off_ext;
  assign rd_off_ext = SW'(rd_off_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_active_r <= CNT_W'(bin_cnt_r);
      out_total_r  <= total_ext[FIELD_CW-1:0];
      case (cmd.res_sel)
        RES_INS: begin
          out_bin_r   <= hold_bin_r;
          out_first_r <= first_ext[FIELD_CW-1:0];
          out_cap_r   <= hold_cap_r;
        end
        RES_HIT: begin
          out_bin_r   <= rd_bin_r;
          out_first_r <= rd_off_ext[FIELD_CW-1:0];
          out_cap_r   <= rd_cap_r;
        end
        default: begin
          out_bin_r   <= '0;
          out_first_r <= '0;
          out_cap_r   <= '0;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_bin_index      = out_bin_r;
  assign out_first_command  = out_first_r;
  assign out_bin_capacity   = out_cap_r;
  assign out_active_bins    = out_active_r;
  assign out_total_commands = out_total_r;

  always_comb begin
    sts.in_valid      = in_valid;
    sts.func_in       = func_t'(in_func);
    sts.func_q        = func_t'(func_r);
    sts.sweep_last    = (sweep_r == SWEEP_END);
    sts.precheck_full = (bin_dbl >= {1'b0, slots});
    sts.precheck_ovf  = (sum > CMD_MAX);
    sts.slot_valid    = rd_valid_r;
    sts.slot_match    = (rd_pa_r == pa_r) && (rd_pipe_r == pipe_r) &&
                        (rd_heap_r == heap_r) && (rd_mat_r == mat_r);
    sts.probe_last    = (probe_r == mask_r);
    sts.out_free      = !out_valid_r || !out_stall;
  end

endmodule
`default_nettype wire

FILE: rtl/core/dbh_ctrl.sv
// ----------------------------------------------------------------------------
// dbh_ctrl
// sequencer for hash, probe, clear sweep and result hand-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "draw_bin_hash_table_defines.svh"
module dbh_ctrl
  import dbh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_HASH  = 7'b0000010,
    S_SEED  = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_CLEAR = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  status_t           fin_status_r, fin_status_nxt;
  res_sel_t          res_sel_r, res_sel_nxt;
  logic              clr_item_r, clr_item_nxt;

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    fin_status_nxt = fin_status_r;
    res_sel_nxt    = res_sel_r;
    clr_item_nxt   = clr_item_r;
    cmd            = '0;
    cmd.word_sel   = step_r;
    cmd.out_status = fin_status_r;
    cmd.res_sel    = res_sel_r;
    case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.in_valid) begin
          step_nxt    = '0;
          fin_status_nxt = STAT_OK;
          res_sel_nxt = RES_ZERO;
          case (sts.func_in)
            FUNC_CLEAR: begin
              cmd.clear_counts = 1'b1;
              cmd.sweep_start  = 1'b1;
              clr_item_nxt     = 1'b1;
              state_nxt        = S_CLEAR;
            end
            FUNC_NONE: state_nxt = S_DONE;
            default:   state_nxt = S_HASH;
          endcase
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        cmd.seed  = 1'b1;
        state_nxt = S_READ;
        if (sts.func_q == FUNC_INSERT) begin
          if (sts.precheck_full) begin
            fin_status_nxt = STAT_FULL;
            state_nxt      = S_DONE;
          end else if (sts.precheck_ovf) begin
            fin_status_nxt = STAT_OVERFLOW;
            state_nxt      = S_DONE;
          end
        end
      end
      S_READ: begin
        cmd.read_en = 1'b1;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_DONE;
        if (sts.func_q == FUNC_INSERT) begin
          if (!sts.slot_valid) begin
            cmd.ins_write  = 1'b1;
            fin_status_nxt = STAT_OK;
            res_sel_nxt    = RES_INS;
          end else if (sts.probe_last) begin
            fin_status_nxt = STAT_FULL;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end
        end else begin
          if (!sts.slot_valid) begin
            fin_status_nxt = STAT_NOT_FOUND;
          end else if (sts.slot_match) begin
            fin_status_nxt = STAT_OK;
            res_sel_nxt    = RES_HIT;
          end else if (sts.probe_last) begin
            fin_status_nxt = STAT_NOT_FOUND;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = S_READ;
          end
        end
      end
      S_CLEAR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt    = clr_item_r ? S_DONE : S_IDLE;
          clr_item_nxt = 1'b0;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      step_r       <= '0;
      fin_status_r <= STAT_OK;
      res_sel_r    <= RES_ZERO;
      clr_item_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      fin_status_r <= fin_status_nxt;
      res_sel_r    <= res_sel_nxt;
      clr_item_r   <= clr_item_nxt;
    end
  end

  `DBH_ASSERT_NEXT(a_hash_to_seed, clk, rst_n, state_r == S_HASH && step_r == LAST_STEP, state_r == S_SEED)
  `DBH_ASSERT_NEXT(a_read_to_cmp, clk, rst_n, state_r == S_READ, state_r == S_CMP)
  `DBH_ASSERT_SAME(a_write_only_free, clk, rst_n, cmd.ins_write, !sts.slot_valid && state_r == S_CMP)
  `DBH_ASSERT_NEXT(a_load_to_idle, clk, rst_n, cmd.out_load, state_r == S_IDLE)

endmodule
`default_nettype wire

FILE: rtl/core/draw_bin_hash_table.sv
// insert and find: 5 hash steps, 1 seed, then a registered read and a compare for each probe,
//   then the hand-off; a refused insert goes from the seed straight to the hand-off
// clear: one sweep over the whole slot memory (largest power of two within TABLE_DEPTH),
//   then the hand-off; unused func goes straight to the hand-off
// one item at a time: the input stalls until the item's result is loaded into the result
//   register; reset: synchronous active low, same sweep before use
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// draw_bin_hash_table
// open-addressed bin table with fnv-1a key hash and linear probing
// ----------------------------------------------------------------------------
module draw_bin_hash_table
  import dbh_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = DEF_TABLE_DEPTH,
  parameter int unsigned COMMAND_BITS = DEF_COMMAND_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // table size register
  input  wire logic                cfg_wr_en,
  input  wire logic [LG_W-1:0]     cfg_wr_data,
  // item input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_func,
  input  wire logic [3:0]          in_phase,
  input  wire logic [2:0]          in_alpha,
  input  wire logic [WORD_W-1:0]   in_pipeline,
  input  wire logic [WORD_W-1:0]   in_geometry_heap,
  input  wire logic [WORD_W-1:0]   in_material_template,
  input  wire logic [FIELD_CW-1:0] in_demand,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic [BIN_W-1:0]         out_bin_index,
  output logic [FIELD_CW-1:0]      out_first_command,
  output logic [FIELD_CW-1:0]      out_bin_capacity,
  output logic [CNT_W-1:0]         out_active_bins,
  output logic [FIELD_CW-1:0]      out_total_commands
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: hash steps, probe loop, clear sweep, result hand-off
  dbh_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // datapath: key capture, hash multiplier, slot memory, running totals,
  // result register so a finished transfer can wait while the next item enters
  dbh_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .COMMAND_BITS (COMMAND_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (in_func),
    .in_phase             (in_phase),
    .in_alpha             (in_alpha),
    .in_pipeline          (in_pipeline),
    .in_geometry_heap     (in_geometry_heap),
    .in_material_template (in_material_template),
    .in_demand            (in_demand),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_bin_index        (out_bin_index),
    .out_first_command    (out_first_command),
    .out_bin_capacity     (out_bin_capacity),
    .out_active_bins      (out_active_bins),
    .out_total_commands   (out_total_commands)
  );

endmodule
`default_nettype wire

FILE: dv/tb_draw_bin_hash_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_draw_bin_hash_table
// self-checking bench for the draw bin hash table: a queue-fed driver, an
// in-bench copy of the hash, probe and bin bookkeeping that predicts every
// result, and a monitor that compares each result transfer field by field
// ----------------------------------------------------------------------------
module tb_draw_bin_hash_table;
  import dbh_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam longint      CMD_MAX    = (64'd1 << 20) - 1;
  localparam int unsigned WDOG_LIMIT = 40000;
  localparam int unsigned HOLD_LEN   = 400;

  typedef struct packed {
    logic [3:0]  phase;
    logic [2:0]  alpha;
    logic [31:0] pipeline;
    logic [31:0] heap;
    logic [31:0] material;
  } bin_key_t;

  typedef struct packed {
    logic [1:0]  func;
    bin_key_t    key;
    logic [19:0] demand;
  } table_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  bin_index;
    logic [19:0] first_command;
    logic [19:0] bin_capacity;
    logic [9:0]  active_bins;
    logic [19:0] total_commands;
  } bin_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [3:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall = 1'b0;
  table_op_t   drv_op = '0;
  table_op_t   next_op;
  logic [1:0]  out_status;
  logic [8:0]  out_bin_index;
  logic [19:0] out_first_command, out_bin_capacity, out_total_commands;
  logic [9:0]  out_active_bins;

  // stimulus and expectation stores
  table_op_t   op_queue[$];
  bin_result_t result_queue[$];
  bin_key_t    key_pool[$];

  // predicted table state
  bit          tbl_valid[DEPTH];
  bin_key_t    tbl_key[DEPTH];
  logic [8:0]  tbl_bin[DEPTH];
  logic [19:0] tbl_offset[DEPTH];
  logic [19:0] tbl_cap[DEPTH];
  int unsigned tbl_bins;
  longint      tbl_total;
  logic [3:0]  tbl_size_lg = SIZE_LG_RESET;

  int          err_n = 0;
  int          results_seen = 0;
  int          hold_left = 0;
  int          wdog = 0;
  bit          calm = 1'b0;

  always #2 clk = ~clk;

  draw_bin_hash_table dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_func              (drv_op.func),
    .in_phase             (drv_op.key.phase),
    .in_alpha             (drv_op.key.alpha),
    .in_pipeline          (drv_op.key.pipeline),
    .in_geometry_heap     (drv_op.key.heap),
    .in_material_template (drv_op.key.material),
    .in_demand            (drv_op.demand),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_bin_index        (out_bin_index),
    .out_first_command    (out_first_command),
    .out_bin_capacity     (out_bin_capacity),
    .out_active_bins      (out_active_bins),
    .out_total_commands   (out_total_commands)
  );

  // fnv-1a over the five key words, folded by the upper half
  function automatic logic [31:0] key_hash(bin_key_t k);
    logic [31:0] h;
    logic [31:0] words[5];
    words = '{{28'd0, k.phase}, {29'd0, k.alpha}, k.pipeline, k.heap, k.material};
    h = FNV_BASIS;
    for (int i = 0; i < 5; i++) h = (h ^ words[i]) * FNV_PRIME;
    return h ^ (h >> FOLD_SHIFT);
  endfunction

  // applies one accepted operation to the predicted table and gives its result
  function automatic bin_result_t apply_table_op(table_op_t op);
    bin_result_t r;
    int unsigned slots, mask, idx;
    r = '0;
    slots = 1 << tbl_size_lg;
    while (slots > 1 && slots > DEPTH) slots >>= 1;
    mask = slots - 1;
    idx = key_hash(op.key) & mask;
    case (op.func)
      FUNC_CLEAR: begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        tbl_bins = 0;
        tbl_total = 0;
      end
      FUNC_INSERT: begin
        if (tbl_bins * 2 >= slots) r.status = STAT_FULL;
        else if (tbl_total + op.demand > CMD_MAX) r.status = STAT_OVERFLOW;
        else begin
          r.status = STAT_FULL;
          for (int p = 0; p < slots; p++) begin
            if (!tbl_valid[idx]) begin
              tbl_valid[idx] = 1'b1;
              tbl_key[idx] = op.key;
              tbl_bin[idx] = tbl_bins[8:0];
              tbl_offset[idx] = tbl_total[19:0];
              tbl_cap[idx] = op.demand;
              r.status = STAT_OK;
              r.bin_index = tbl_bins[8:0];
              r.first_command = tbl_total[19:0];
              r.bin_capacity = op.demand;
              tbl_bins++;
              tbl_total += op.demand;
              break;
            end
            idx = (idx + 1) & mask;
          end
        end
      end
      FUNC_FIND: begin
        r.status = STAT_NOT_FOUND;
        for (int p = 0; p < slots; p++) begin
          if (!tbl_valid[idx]) break;
          if (tbl_key[idx] == op.key) begin
            r.status = STAT_OK;
            r.bin_index = tbl_bin[idx];
            r.first_command = tbl_offset[idx];
            r.bin_capacity = tbl_cap[idx];
            break;
          end
          idx = (idx + 1) & mask;
        end
      end
      default: ;
    endcase
    r.active_bins = tbl_bins[9:0];
    r.total_commands = tbl_total[19:0];
    return r;
  endfunction

  // driver: predicts on each input transfer, then offers the next pending item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) result_queue = {result_queue, apply_table_op(drv_op)};
      if (op_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
        next_op = op_queue.pop_front();
        drv_op <= next_op;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: checks result transfers and drives the receiver's stall
  always @(posedge clk) begin
    bin_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (result_queue.size() == 0) begin
        $error("result transfer with nothing expected");
        err_n++;
      end else begin
        exp_r = result_queue.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, out_status); err_n++;
        end
        if (out_bin_index !== exp_r.bin_index) begin
          $error("bin_index exp %0d got %0d", exp_r.bin_index, out_bin_index); err_n++;
        end
        if (out_first_command !== exp_r.first_command) begin
          $error("first_command exp %0d got %0d", exp_r.first_command, out_first_command);
          err_n++;
        end
        if (out_bin_capacity !== exp_r.bin_capacity) begin
          $error("bin_capacity exp %0d got %0d", exp_r.bin_capacity, out_bin_capacity);
          err_n++;
        end
        if (out_active_bins !== exp_r.active_bins) begin
          $error("active_bins exp %0d got %0d", exp_r.active_bins, out_active_bins); err_n++;
        end
        if (out_total_commands !== exp_r.total_commands) begin
          $error("total_commands exp %0d got %0d", exp_r.total_commands, out_total_commands);
          err_n++;
        end
      end
      // long hold-off once, so the block backs up and stalls its input
      if (results_seen == 300) hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_LIMIT) begin
      $display("FAIL draw_bin_hash_table");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  function automatic bin_key_t rand_key();
    bin_key_t k;
    k.phase = $urandom_range(0, 15);
    k.alpha = $urandom_range(0, 7);
    k.pipeline = $urandom();
    k.heap = $urandom();
    k.material = $urandom();
    return k;
  endfunction

  task automatic queue_op(logic [1:0] f, bin_key_t k, logic [19:0] d);
    table_op_t op;
    op.func = f;
    op.key = k;
    op.demand = d;
    op_queue = {op_queue, op};
  endtask

  // waits until every item has gone through and every result has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (op_queue.size() != 0 || in_valid || result_queue.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] lg);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= lg;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tbl_size_lg = lg;
  endtask

  initial begin
    bin_key_t    ka, kb, kz, k;
    logic [3:0]  size_plan[12];
    int unsigned pick;
    logic [19:0] dem;

    size_plan = '{4'd10, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd7, 4'd4, 4'd10, 4'd6, 4'd9};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero demand, overflow, duplicate, unused func
    ka = rand_key();
    kb = '1;
    kz = '0;
    queue_op(FUNC_CLEAR, kz, '0);
    queue_op(FUNC_INSERT, ka, 20'd1);
    queue_op(FUNC_INSERT, kb, 20'd0);
    queue_op(FUNC_INSERT, kz, 20'hFFFFF);
    queue_op(FUNC_FIND, ka, '0);
    queue_op(FUNC_FIND, kb, 20'hFFFFF);
    queue_op(FUNC_FIND, kz, '0);
    queue_op(FUNC_INSERT, ka, 20'd77);
    queue_op(FUNC_FIND, ka, '0);
    queue_op(FUNC_NONE, kb, 20'hFFFFF);
    queue_op(FUNC_INSERT, kz, 20'hFFFFD);
    queue_op(FUNC_FIND, kz, '0);
    write_size(4'd1);
    queue_op(FUNC_CLEAR, kb, '1);
    queue_op(FUNC_INSERT, ka, 20'd5);
    queue_op(FUNC_INSERT, kb, 20'd6);
    queue_op(FUNC_FIND, ka, '0);
    queue_op(FUNC_FIND, kb, '0);
    write_size(4'd0);
    queue_op(FUNC_INSERT, kb, 20'd6);
    queue_op(FUNC_FIND, kb, '0);
    queue_op(FUNC_CLEAR, kz, '0);
    queue_op(FUNC_INSERT, kb, 20'd9);
    queue_op(FUNC_INSERT, ka, 20'd9);

    // random phases, one per entry of the size plan
    foreach (size_plan[ph]) begin
      write_size(size_plan[ph]);
      calm = (ph == 3);
      key_pool.delete();
      queue_op(FUNC_CLEAR, rand_key(), 20'($urandom()));
      repeat (155) begin
        pick = $urandom_range(0, 99);
        dem = ($urandom_range(0, 99) < 4) ? 20'($urandom()) : 20'($urandom_range(1, 3000));
        if (pick < 45) begin
          if (key_pool.size() != 0 && $urandom_range(0, 19) == 0)
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
          else begin
            k = rand_key();
            key_pool = {key_pool, k};
          end
          queue_op(FUNC_INSERT, k, dem);
        end else if (pick < 85 && key_pool.size() != 0) begin
          queue_op(FUNC_FIND, key_pool[$urandom_range(0, key_pool.size() - 1)], dem);
        end else if (pick < 95) begin
          // near miss or fresh key
          k = (key_pool.size() != 0) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                                     : rand_key();
          k.material[$urandom_range(0, 31)] ^= 1'b1;
          queue_op(FUNC_FIND, k, dem);
        end else if (pick < 97) begin
          queue_op(FUNC_CLEAR, rand_key(), dem);
        end else begin
          queue_op(FUNC_NONE, rand_key(), dem);
        end
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (50) @(posedge clk);
    if (err_n == 0) begin
      $display("PASS draw_bin_hash_table");
    end else begin
      $display("FAIL draw_bin_hash_table");
    end
    $finish;
  end

endmodule
